>>> sv/bpf_pkg.sv
package bpf_pkg;

    localparam int SCREEN_WIDTH_DEF  = 800;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int MAX_IMAGE_DIM_DEF = 2048;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int DIM_W      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT = 3'd4;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 12'd800;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_ALPHA = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       start_of_image;
    } in_item_t;

    typedef struct packed {
        logic [18:0] screen_offset;
        logic [31:0] argb_color;
        logic        on_screen;
        logic        last_pixel;
    } out_item_t;

    typedef struct packed {
        logic signed [11:0] x_origin;
        logic signed [11:0] y_origin;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic               alpha_present;
    } cfg_t;

    // finished pixel handed from the decoder to the screen mapper
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [31:0]      color;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] height;
    } pix_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W:0] max_dim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        end else if ({1'b0, v} > max_dim) begin
            r = max_dim[DIM_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/bpf_decode.sv
module bpf_decode #(
    parameter int MAX_IMAGE_DIM = bpf_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              consume,
    input  bpf_pkg::in_item_t in_item,
    input  bpf_pkg::cfg_t     cfg,
    output bpf_pkg::pix_t     pix
);
    import bpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_IMAGE_DIM);
    localparam logic [DIM_W:0] MAX_DIM = (DIM_W+1)'(MAX_IMAGE_DIM);

    phase_t           phase_reg, phase_next, phase_eff;
    logic [CNT_W-1:0] col_reg, col_next, col_eff;
    logic [CNT_W-1:0] row_reg, row_next, row_eff;
    logic [1:0]       pad_reg, pad_next, pad_eff;
    logic             done_reg, done_next, done_eff;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       red_reg, red_next;

    logic [DIM_W-1:0] width, height;
    logic             emit, row_end, img_end;

    assign width  = clamp_dim(cfg.image_width, MAX_DIM);
    assign height = clamp_dim(cfg.image_height, MAX_DIM);

    // start of image clears the counters before the byte is looked at
    always_comb begin
        phase_eff = phase_reg;
        col_eff   = col_reg;
        row_eff   = row_reg;
        pad_eff   = pad_reg;
        done_eff  = done_reg;
        if (in_item.start_of_image) begin
            phase_eff = PH_BLUE;
            col_eff   = '0;
            row_eff   = '0;
            pad_eff   = '0;
            done_eff  = 1'b0;
        end
    end

    assign emit = !done_eff && (pad_eff == '0) &&
                  ((phase_eff == PH_ALPHA) || ((phase_eff == PH_RED) && !cfg.alpha_present));
    assign row_end = ((DIM_W+1)'(col_eff) + (DIM_W+1)'(1)) >= (DIM_W+1)'(width);
    assign img_end = ((DIM_W+1)'(row_eff) + (DIM_W+1)'(1)) >= (DIM_W+1)'(height);

    // next state
    always_comb begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pad_next   = pad_reg;
        done_next  = done_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        red_next   = red_reg;
        if (consume) begin
            phase_next = phase_eff;
            col_next   = col_eff;
            row_next   = row_eff;
            pad_next   = pad_eff;
            done_next  = done_eff;
            if (!done_eff) begin
                if (pad_eff != '0) begin
                    pad_next = pad_eff - 2'd1;
                end else begin
                    case (phase_eff)
                        PH_BLUE: begin
                            blue_next  = in_item.pixel_byte;
                            phase_next = PH_GREEN;
                        end
                        PH_GREEN: begin
                            green_next = in_item.pixel_byte;
                            phase_next = PH_RED;
                        end
                        PH_RED: begin
                            red_next   = in_item.pixel_byte;
                            phase_next = cfg.alpha_present ? PH_ALPHA : PH_BLUE;
                        end
                        PH_ALPHA: begin
                            phase_next = PH_BLUE;
                        end
                        default: begin
                            phase_next = PH_BLUE;
                        end
                    endcase
                    if (emit) begin
                        if (row_end) begin
                            col_next = '0;
                            if (img_end) begin
                                done_next = 1'b1;
                                row_next  = '0;
                            end else begin
                                row_next = row_eff + CNT_W'(1);
                                pad_next = cfg.alpha_present ? 2'd0 : width[1:0];
                            end
                        end else begin
                            col_next = col_eff + CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    // outputs
    always_comb begin
        pix.valid  = emit;
        pix.last   = row_end && img_end;
        pix.color  = {(phase_eff == PH_ALPHA) ? in_item.pixel_byte : 8'd0,
                      (phase_eff == PH_RED) ? in_item.pixel_byte : red_reg,
                      green_reg, blue_reg};
        pix.col    = DIM_W'(col_eff);
        pix.row    = DIM_W'(row_eff);
        pix.height = height;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_BLUE;
            col_reg   <= '0;
            row_reg   <= '0;
            pad_reg   <= '0;
            done_reg  <= 1'b1;
            blue_reg  <= '0;
            green_reg <= '0;
            red_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pad_reg   <= pad_next;
            done_reg  <= done_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

`ifndef SYNTH
    a_last_ends_image: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && pix.valid && pix.last |=> done_reg)
        else $error("image not closed after last pixel");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && !(consume && in_item.start_of_image) |=> done_reg)
        else $error("finished image reopened without start");

    a_idle_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && done_reg && !in_item.start_of_image |-> !pix.valid)
        else $error("pixel produced while no image open");
`endif

endmodule

>>> sv/bpf_map.sv
module bpf_map #(
    parameter int SCREEN_WIDTH  = bpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bpf_pkg::SCREEN_HEIGHT_DEF
) (
    input  bpf_pkg::pix_t      pix,
    input  bpf_pkg::cfg_t      cfg,
    output bpf_pkg::out_item_t res
);
    import bpf_pkg::*;

    localparam logic [15:0] SW16 = 16'(SCREEN_WIDTH);
    localparam logic [15:0] SH16 = 16'(SCREEN_HEIGHT);

    logic [15:0] sx, sy;
    logic        vis;
    logic [31:0] prod, off;

    // two's complement in 16 bits, bit 15 is the sign
    assign sx = {{4{cfg.x_origin[11]}}, cfg.x_origin} + {4'b0, pix.col};
    assign sy = {{4{cfg.y_origin[11]}}, cfg.y_origin} + {4'b0, pix.height}
                - 16'd1 - {4'b0, pix.row};

    assign vis  = !sx[15] && (sx < SW16) && !sy[15] && (sy < SH16);
    assign prod = 32'(sy[14:0]) * 32'(SCREEN_WIDTH);
    assign off  = prod + 32'(sx[14:0]);

    always_comb begin
        res.screen_offset = vis ? off[18:0] : '0;
        res.argb_color    = pix.color;
        res.on_screen     = vis;
        res.last_pixel    = pix.last;
    end

endmodule

>>> sv/bmp_pixel_stream_to_framebuffer_unit.sv
// A byte waits in the input register, its pixel in the output register that drives m_data.
// One byte per cycle while m_data is not stalled; 3 or 4 bytes per pixel, none from padding.
// The decode counters and the constant multiply for the offset sit in one stage.
// Reset (aresetn low, synchronous): both channels empty, counters cleared,
// image marked finished, registers back to x/y origin 0, 800x480, 24-bit.
module bmp_pixel_stream_to_framebuffer_unit #(
    parameter int SCREEN_WIDTH  = bpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bpf_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_IMAGE_DIM = bpf_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bpf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpf_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bpf_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bpf_pkg::out_item_t                  m_data
);
    import bpf_pkg::*;

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      advance;
    pix_t      pix;
    out_item_t res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_origin      <= '0;
            cfg_reg.y_origin      <= '0;
            cfg_reg.image_width   <= IMAGE_WIDTH_RST;
            cfg_reg.image_height  <= IMAGE_HEIGHT_RST;
            cfg_reg.alpha_present <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_X_ORIGIN:      cfg_reg.x_origin      <= cfg_wr_data;
                CFG_Y_ORIGIN:      cfg_reg.y_origin      <= cfg_wr_data;
                CFG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_wr_data;
                CFG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_wr_data;
                CFG_ALPHA_PRESENT: cfg_reg.alpha_present <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    bpf_decode #(
        .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .consume (advance),
        .in_item (in_data_reg),
        .cfg     (cfg_reg),
        .pix     (pix)
    );

    bpf_map #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_map (
        .pix (pix),
        .cfg (cfg_reg),
        .res (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && pix.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && pix.valid) begin
            out_data_reg <= res;
        end
    end

`ifndef SYNTH
    a_out_not_overwritten: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result overwritten");

    a_offset_in_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.on_screen |->
            (32'(out_data_reg.screen_offset) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)))
        else $error("offset beyond framebuffer");

    a_offscreen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg.on_screen |-> out_data_reg.screen_offset == '0)
        else $error("off-screen pixel with nonzero offset");

    a_input_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> !in_valid_reg || $past(s_valid))
        else $error("input register stuck with free output");
`endif

endmodule
